FILE: rtl/tlf_pkg.sv
// types, codes and constants shared by the telnet receive line filter
package tlf_pkg;

    localparam int BYTE_W  = 8;
    localparam int INDEX_W = 12;
    localparam int COUNT_W = 13;

    localparam logic [COUNT_W-1:0] LIMIT_RESET = 13'd514;
    localparam logic [COUNT_W-1:0] LIMIT_MIN   = 13'd1;
    localparam logic [COUNT_W-1:0] LIMIT_MAX   = 13'd4096;

    localparam logic [BYTE_W-1:0] TN_IAC     = 8'd255;
    localparam logic [BYTE_W-1:0] TN_DONT    = 8'd254;
    localparam logic [BYTE_W-1:0] TN_DO      = 8'd253;
    localparam logic [BYTE_W-1:0] TN_WONT    = 8'd252;
    localparam logic [BYTE_W-1:0] TN_WILL    = 8'd251;
    localparam logic [BYTE_W-1:0] OPT_BINARY = 8'd0;
    localparam logic [BYTE_W-1:0] OPT_SGA    = 8'd3;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'd13;
    localparam logic [BYTE_W-1:0] CH_LF      = 8'd10;
    localparam logic [BYTE_W-1:0] CH_NUL     = 8'd0;

    localparam logic KIND_DATA  = 1'b0;
    localparam logic KIND_REPLY = 1'b1;

    typedef enum logic [2:0] {
        MODE_DATA = 3'd0,
        MODE_CMD  = 3'd1,
        MODE_DO   = 3'd2,
        MODE_DONT = 3'd3,
        MODE_WILL = 3'd4,
        MODE_WONT = 3'd5
    } mode_t;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  byte_value;
        logic [INDEX_W-1:0] line_index;
        logic               line_end;
        logic               last;
    } res_t;

    typedef struct packed {
        mode_t              mode_next;
        logic [COUNT_W-1:0] count_next;
        logic [1:0]         nres;
        res_t [2:0]         res;
    } parse_t;

endpackage

FILE: rtl/tlf_if.sv
// valid/ready channel interfaces for received bytes, results and configuration
interface tlf_in_if;
    logic                       valid;
    logic                       ready;
    logic [tlf_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tlf_out_if;
    logic                        valid;
    logic                        ready;
    logic                        kind;
    logic [tlf_pkg::BYTE_W-1:0]  byte_value;
    logic [tlf_pkg::INDEX_W-1:0] line_index;
    logic                        line_end;
    logic                        last;

    modport source (output valid, output kind, output byte_value, output line_index,
                    output line_end, output last, input ready);
    modport sink   (input valid, input kind, input byte_value, input line_index,
                    input line_end, input last, output ready);
endinterface

interface tlf_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tlf_pkg::COUNT_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/telnet_receive_line_filter.sv
// telnet receive filter top level: input register, parser, result burst register
// path: a byte goes from the input register through the parser into the result register
// throughput: one byte per cycle when tx is ready; a reply to DO holds the result
// register for its three reply items, during which at most one more byte is taken in
// reset: rst_n clears parser mode, line count, valid flags and sets line_limit to 514
module telnet_receive_line_filter (
    input  logic      clk,
    input  logic      rst_n,
    tlf_in_if.sink    rx,
    tlf_out_if.source tx,
    tlf_cfg_if.sink   cfg
);

    logic                        in_vld_reg;
    logic                        in_vld_next;
    logic [tlf_pkg::BYTE_W-1:0]  in_byte_reg;
    logic [tlf_pkg::BYTE_W-1:0]  in_byte_next;
    tlf_pkg::mode_t              mode_reg;
    tlf_pkg::mode_t              mode_next;
    logic [tlf_pkg::COUNT_W-1:0] count_reg;
    logic [tlf_pkg::COUNT_W-1:0] count_next;
    logic [tlf_pkg::COUNT_W-1:0] limit_reg;
    logic [tlf_pkg::COUNT_W-1:0] limit_next;
    logic                        busy_reg;
    logic                        busy_next;
    logic [1:0]                  total_reg;
    logic [1:0]                  total_next;
    logic [1:0]                  pos_reg;
    logic [1:0]                  pos_next;
    tlf_pkg::res_t [2:0]         res_reg;
    tlf_pkg::res_t [2:0]         res_next;

    tlf_pkg::parse_t             parse;
    tlf_pkg::res_t               cur;
    logic                        out_fire;
    logic                        at_last;
    logic                        stage_free;
    logic                        in_take;

    tlf_parser u_parser (
        .rx_byte    (in_byte_reg),
        .mode       (mode_reg),
        .line_count (count_reg),
        .line_limit (limit_reg),
        .parse      (parse)
    );

    assign out_fire   = busy_reg && tx.ready;
    assign at_last    = (pos_reg == (total_reg - 2'd1));
    assign stage_free = !busy_reg || (tx.ready && at_last);
    assign in_take    = in_vld_reg && stage_free;

    assign rx.ready  = !in_vld_reg || stage_free;
    assign cfg.ready = 1'b1;

    assign cur           = res_reg[pos_reg];
    assign tx.valid      = busy_reg;
    assign tx.kind       = cur.kind;
    assign tx.byte_value = cur.byte_value;
    assign tx.line_index = cur.line_index;
    assign tx.line_end   = cur.line_end;
    assign tx.last       = cur.last;

    always_comb
    begin
        in_vld_next  = in_vld_reg;
        in_byte_next = in_byte_reg;
        if (rx.valid && rx.ready)
        begin
            in_vld_next  = 1'b1;
            in_byte_next = rx.rx_byte;
        end
        else if (in_take)
        begin
            in_vld_next = 1'b0;
        end
    end

    always_comb
    begin
        limit_next = limit_reg;
        if (cfg.valid && cfg.ready)
        begin
            limit_next = cfg.data;
        end
    end

    always_comb
    begin
        mode_next  = mode_reg;
        count_next = count_reg;
        busy_next  = busy_reg;
        total_next = total_reg;
        pos_next   = pos_reg;
        res_next   = res_reg;
        if (out_fire)
        begin
            if (at_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                pos_next = pos_reg + 2'd1;
            end
        end
        if (in_take)
        begin
            mode_next  = parse.mode_next;
            count_next = parse.count_next;
            if (parse.nres != 2'd0)
            begin
                busy_next  = 1'b1;
                total_next = parse.nres;
                pos_next   = 2'd0;
                res_next   = parse.res;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            mode_reg   <= tlf_pkg::MODE_DATA;
            count_reg  <= '0;
            limit_reg  <= tlf_pkg::LIMIT_RESET;
            busy_reg   <= 1'b0;
            total_reg  <= 2'd1;
            pos_reg    <= 2'd0;
        end
        else
        begin
            in_vld_reg <= in_vld_next;
            mode_reg   <= mode_next;
            count_reg  <= count_next;
            limit_reg  <= limit_next;
            busy_reg   <= busy_next;
            total_reg  <= total_next;
            pos_reg    <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_byte_reg <= in_byte_next;
        res_reg     <= res_next;
    end

endmodule

FILE: rtl/tlf_parser.sv
// combinational telnet command parser and line assembler for one byte
module tlf_parser (
    input  logic [tlf_pkg::BYTE_W-1:0]  rx_byte,
    input  tlf_pkg::mode_t              mode,
    input  logic [tlf_pkg::COUNT_W-1:0] line_count,
    input  logic [tlf_pkg::COUNT_W-1:0] line_limit,
    output tlf_pkg::parse_t             parse
);

    logic [tlf_pkg::COUNT_W-1:0] lim;
    logic [tlf_pkg::COUNT_W-1:0] count_inc;
    logic                        ends;
    logic [tlf_pkg::BYTE_W-1:0]  reply;

    always_comb
    begin
        if (line_limit < tlf_pkg::LIMIT_MIN)
        begin
            lim = tlf_pkg::LIMIT_MIN;
        end
        else if (line_limit > tlf_pkg::LIMIT_MAX)
        begin
            lim = tlf_pkg::LIMIT_MAX;
        end
        else
        begin
            lim = line_limit;
        end
    end

    assign count_inc = line_count + 13'd1;
    assign ends      = (count_inc >= lim) || (rx_byte == tlf_pkg::CH_LF);
    assign reply     = ((rx_byte == tlf_pkg::OPT_SGA) || (rx_byte == tlf_pkg::OPT_BINARY))
                       ? tlf_pkg::TN_WILL : tlf_pkg::TN_WONT;

    always_comb
    begin
        parse            = '0;
        parse.mode_next  = tlf_pkg::MODE_DATA;
        parse.count_next = line_count;
        unique case (mode)
            tlf_pkg::MODE_CMD:
            begin
                priority if (rx_byte == tlf_pkg::TN_DO)
                begin
                    parse.mode_next = tlf_pkg::MODE_DO;
                end
                else if (rx_byte == tlf_pkg::TN_DONT)
                begin
                    parse.mode_next = tlf_pkg::MODE_DONT;
                end
                else if (rx_byte == tlf_pkg::TN_WILL)
                begin
                    parse.mode_next = tlf_pkg::MODE_WILL;
                end
                else if (rx_byte == tlf_pkg::TN_WONT)
                begin
                    parse.mode_next = tlf_pkg::MODE_WONT;
                end
                else
                begin
                    parse.mode_next = tlf_pkg::MODE_DATA;
                end
            end
            tlf_pkg::MODE_DO:
            begin
                parse.nres              = 2'd3;
                parse.res[0].kind       = tlf_pkg::KIND_REPLY;
                parse.res[0].byte_value = tlf_pkg::TN_IAC;
                parse.res[1].kind       = tlf_pkg::KIND_REPLY;
                parse.res[1].byte_value = reply;
                parse.res[2].kind       = tlf_pkg::KIND_REPLY;
                parse.res[2].byte_value = rx_byte;
                parse.res[2].last       = 1'b1;
            end
            tlf_pkg::MODE_DONT, tlf_pkg::MODE_WILL, tlf_pkg::MODE_WONT:
            begin
                parse.nres = 2'd0;
            end
            default:
            begin
                priority if (rx_byte == tlf_pkg::TN_IAC)
                begin
                    parse.mode_next = tlf_pkg::MODE_CMD;
                end
                else if (rx_byte == tlf_pkg::CH_NUL)
                begin
                    parse.nres = 2'd0;
                end
                else if ((line_count == '0) && (rx_byte == tlf_pkg::CH_CR))
                begin
                    parse.nres = 2'd0;
                end
                else
                begin
                    parse.nres              = 2'd1;
                    parse.res[0].kind       = tlf_pkg::KIND_DATA;
                    parse.res[0].byte_value = rx_byte;
                    parse.res[0].line_index = line_count[tlf_pkg::INDEX_W-1:0];
                    parse.res[0].line_end   = ends;
                    parse.res[0].last       = 1'b1;
                    parse.count_next        = ends ? '0 : count_inc;
                end
            end
        endcase
    end

endmodule

FILE: rtl/tlf_checker.sv
// port-level assertions for the telnet receive line filter, bound to the top level
module tlf_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        tx_valid,
    input logic                        tx_ready,
    input logic                        tx_kind,
    input logic [tlf_pkg::BYTE_W-1:0]  tx_byte_value,
    input logic [tlf_pkg::INDEX_W-1:0] tx_line_index,
    input logic                        tx_line_end,
    input logic                        tx_last
);

    // stalled result item holds
    a_tx_hold: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && !tx_ready |=> tx_valid && $stable(tx_kind) && $stable(tx_byte_value)
        && $stable(tx_line_index) && $stable(tx_line_end) && $stable(tx_last))
        else $error("result item changed while stalled");

    // a data item is always the only result of its byte
    a_data_last: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_kind == tlf_pkg::KIND_DATA) |-> tx_last)
        else $error("data item without last");

    // reply items carry no line position
    a_reply_clean: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_kind == tlf_pkg::KIND_REPLY) |-> (tx_line_index == '0) && !tx_line_end)
        else $error("reply item with line fields set");

    // leading reply items are IAC or WILL or WONT
    a_reply_head: assert property (@(posedge clk) disable iff (!rst_n)
        tx_valid && (tx_kind == tlf_pkg::KIND_REPLY) && !tx_last |->
        (tx_byte_value == tlf_pkg::TN_IAC) || (tx_byte_value == tlf_pkg::TN_WILL)
        || (tx_byte_value == tlf_pkg::TN_WONT))
        else $error("bad reply header byte");

endmodule

bind telnet_receive_line_filter tlf_checker u_tlf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .tx_valid      (tx.valid),
    .tx_ready      (tx.ready),
    .tx_kind       (tx.kind),
    .tx_byte_value (tx.byte_value),
    .tx_line_index (tx.line_index),
    .tx_line_end   (tx.line_end),
    .tx_last       (tx.last)
);
